// ----- rtl/core/y2r_pkg.sv -----
`default_nettype none

package y2r_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLOR_MATRIX = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_ORDER = 2'd1;
  localparam logic [1:0] CFG_CHROMA_ORDER = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 1;

  // Color matrix selection codes.
  localparam logic MATRIX_BT601 = 1'b0;
  localparam logic MATRIX_BT709 = 1'b1;

  // Q10 coefficients.
  localparam logic signed [12:0] COEF_Y       = 13'sd1192;
  localparam logic signed [12:0] COEF_RV_601  = 13'sd1634;
  localparam logic signed [12:0] COEF_GU_601  = -13'sd401;
  localparam logic signed [12:0] COEF_GV_601  = -13'sd833;
  localparam logic signed [12:0] COEF_BU_601  = 13'sd2065;
  localparam logic signed [12:0] COEF_RV_709  = 13'sd1836;
  localparam logic signed [12:0] COEF_GU_709  = -13'sd218;
  localparam logic signed [12:0] COEF_GV_709  = -13'sd546;
  localparam logic signed [12:0] COEF_BU_709  = 13'sd2166;

  localparam logic [7:0]         LUMA_OFFSET  = 8'd16;
  localparam logic signed [21:0] ROUND_BIAS   = 22'sd512;
  localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] chroma_first;
    logic [7:0] chroma_second;
    logic       end_of_row;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_left;
    logic [31:0] pixel_right;
    logic        row_last;
  } out_t;

  // Chroma products shared by both pixel lanes.
  typedef struct packed {
    logic signed [20:0] rv_v;
    logic signed [20:0] gu_u;
    logic signed [20:0] gv_v;
    logic signed [20:0] bu_u;
  } chroma_prod_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

endpackage

`default_nettype wire

// ----- rtl/core/y2r_chroma.sv -----
`default_nettype none

module y2r_chroma (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [7:0]            chroma_first_i,
  input  wire logic [7:0]            chroma_second_i,
  input  wire logic                  color_matrix_i,
  input  wire logic                  chroma_order_i,
  output y2r_pkg::chroma_prod_t      prod_o
);
  import y2r_pkg::*;

  logic signed [7:0]  c0, c1;
  logic signed [20:0] u_x, v_x;
  logic signed [12:0] rv, gu, gv, bu;
  chroma_prod_t       prod_d, prod_q;

  // Subtracting 128 from an unsigned byte is a flip of its top bit.
  assign c0 = $signed({~chroma_first_i[7], chroma_first_i[6:0]});
  assign c1 = $signed({~chroma_second_i[7], chroma_second_i[6:0]});

  always_comb begin
    if (chroma_order_i) begin
      u_x = 21'(c1);
      v_x = 21'(c0);
    end else begin
      u_x = 21'(c0);
      v_x = 21'(c1);
    end
    if (color_matrix_i == MATRIX_BT709) begin
      rv = COEF_RV_709;
      gu = COEF_GU_709;
      gv = COEF_GV_709;
      bu = COEF_BU_709;
    end else begin
      rv = COEF_RV_601;
      gu = COEF_GU_601;
      gv = COEF_GV_601;
      bu = COEF_BU_601;
    end
    prod_d.rv_v = v_x * 21'(rv);
    prod_d.gu_u = u_x * 21'(gu);
    prod_d.gv_v = v_x * 21'(gv);
    prod_d.bu_u = u_x * 21'(bu);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- rtl/core/y2r_lane.sv -----
`default_nettype none

module y2r_lane (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [7:0]            luma_i,
  input  y2r_pkg::chroma_prod_t      prod_i,
  output y2r_pkg::rgb_t              rgb_o
);
  import y2r_pkg::*;

  logic signed [19:0] y_x;
  logic signed [19:0] yy_d, yy_q;
  logic signed [21:0] sum_r, sum_g, sum_b;

  // Round-shifted sum limited to one byte: negative gives 0, above 255 gives 255.
  function automatic logic [7:0] clamp_px(input logic signed [21:0] s);
    logic [7:0] res;
    if (s[21]) begin
      res = 8'd0;
    end else if (|s[20:18]) begin
      res = 8'hFF;
    end else begin
      res = s[17:10];
    end
    return res;
  endfunction

  assign y_x  = $signed({12'd0, luma_i}) - $signed({12'd0, LUMA_OFFSET});
  assign yy_d = y_x * 20'(COEF_Y);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yy_q <= yy_d;
    end
  end

  assign sum_r = 22'(yy_q) + 22'(prod_i.rv_v) + ROUND_BIAS;
  assign sum_g = 22'(yy_q) + 22'(prod_i.gu_u) + 22'(prod_i.gv_v) + ROUND_BIAS;
  assign sum_b = 22'(yy_q) + 22'(prod_i.bu_u) + ROUND_BIAS;

  assign rgb_o.r = clamp_px(sum_r);
  assign rgb_o.g = clamp_px(sum_g);
  assign rgb_o.b = clamp_px(sum_b);

endmodule

`default_nettype wire

// ----- rtl/core/yuv420_pair_to_rgba_converter.sv -----
// Results are registered: an accepted transaction is captured in the stage-1 registers, and
// done_o and result_o are then registered from them in the merge stage.
// Throughput: one pixel pair per clock; busy_o stays low, so start_i may be held high.
// The rate is set by the two pixel lanes and the shared chroma multipliers, all pipelined.
// Reset (rst_ni low, asynchronous) clears the pipeline valid bits and all three
// configuration registers to zero; the result receiver cannot stall the block.
`default_nettype none

module yuv420_pair_to_rgba_converter (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output      logic                                busy_o,
  input  y2r_pkg::in_t                             data_i,
  output      logic                                done_o,
  output y2r_pkg::out_t                            result_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [y2r_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [y2r_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import y2r_pkg::*;

  // Configuration registers. Writes to an index outside the list are dropped,
  // and only bit 0 of the write data is kept.
  logic color_matrix_q, output_order_q, chroma_order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_matrix_q <= 1'b0;
      output_order_q <= 1'b0;
      chroma_order_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOR_MATRIX: color_matrix_q <= cfg_wdata_i[0];
        CFG_OUTPUT_ORDER: output_order_q <= cfg_wdata_i[0];
        CFG_CHROMA_ORDER: chroma_order_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // The block never holds off a transaction: busy_o is tied low, so every start_i is accepted.
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Stage 1: the luma products in each lane and the shared chroma products are
  // registered. The valid bit and the end-of-row flag travel alongside.
  logic s1_valid_q;
  logic s1_eor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_eor_q <= data_i.end_of_row;
    end
  end

  chroma_prod_t prod;

  y2r_chroma u_chroma (
    .clk_i           (clk_i),
    .en_i            (accept),
    .chroma_first_i  (data_i.chroma_first),
    .chroma_second_i (data_i.chroma_second),
    .color_matrix_i  (color_matrix_q),
    .chroma_order_i  (chroma_order_q),
    .prod_o          (prod)
  );

  // Two identical lanes, one per pixel of the pair. Both read the same chroma
  // products, which is what 4:2:0 sharing means horizontally.
  rgb_t rgb_left, rgb_right;

  y2r_lane u_lane_left (
    .clk_i  (clk_i),
    .en_i   (accept),
    .luma_i (data_i.luma_first),
    .prod_i (prod),
    .rgb_o  (rgb_left)
  );

  y2r_lane u_lane_right (
    .clk_i  (clk_i),
    .en_i   (accept),
    .luma_i (data_i.luma_second),
    .prod_i (prod),
    .rgb_o  (rgb_right)
  );

  // Stage 2: merge the lane outputs into packed pixels. With output_order low the
  // low byte is blue (BGRA); with it high the low byte is red (RGBA). Alpha is opaque.
  function automatic logic [31:0] pack_px(input rgb_t px, input logic rgba);
    logic [31:0] res;
    if (rgba) begin
      res = {ALPHA_OPAQUE, px.b, px.g, px.r};
    end else begin
      res = {ALPHA_OPAQUE, px.r, px.g, px.b};
    end
    return res;
  endfunction

  out_t result_d, result_q;
  logic done_q;

  always_comb begin
    result_d.pixel_left  = pack_px(rgb_left, output_order_q);
    result_d.pixel_right = pack_px(rgb_right, output_order_q);
    result_d.row_last    = s1_eor_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Every accepted transaction yields a result after the stage-1 and merge registers.
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted transaction produced no result");

  // A result never appears without a transaction that passed the stage-1 and merge registers.
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result without a matching transaction");

  // The end-of-row flag follows its pair through the pipeline.
  a_row_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.row_last == $past(data_i.end_of_row, 2))
    else $error("row_last does not match its transaction");

  // The merge stage always places opaque alpha in the top byte of both pixels.
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.pixel_left[31:24] == ALPHA_OPAQUE) &&
               (result_o.pixel_right[31:24] == ALPHA_OPAQUE))
    else $error("alpha byte is not opaque");

endmodule

`default_nettype wire

// ----- verif/tb_yuv420_pair_to_rgba_converter.sv -----
`default_nettype none

module tb_yuv420_pair_to_rgba_converter;
  import y2r_pkg::*;

  // Codes of the two one-bit registers that the package leaves unnamed.
  localparam logic ORDER_BGRA     = 1'b0;
  localparam logic ORDER_RGBA     = 1'b1;
  localparam logic CHROMA_U_FIRST = 1'b0;
  localparam logic CHROMA_V_FIRST = 1'b1;

  // The index port is two bits wide, so one index addresses no register at all.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // Margin at the end that covers the block's answer to the last acceptance.
  localparam int unsigned SETTLE_CYCLES = 10;
  // Cycles without any accepted transaction, result or register write before giving up.
  localparam int unsigned STALL_LIMIT   = 500;
  localparam int unsigned RANDOM_PAIRS  = 100;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic                 busy_o;
  in_t                  data_i      = '0;
  logic                 done_o;
  out_t                 result_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  yuv420_pair_to_rgba_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .data_i      (data_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the three configuration registers, updated when a write is seen
  // at the port, so predictions always use the setting the block itself holds.
  logic shadow_matrix = MATRIX_BT601;
  logic shadow_order  = ORDER_BGRA;
  logic shadow_chroma = CHROMA_U_FIRST;

  // Pixel pairs predicted for accepted transactions, oldest first.
  out_t        pending_pixels[$];
  int unsigned pairs_sent    = 0;
  int unsigned pairs_checked = 0;
  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned sender_idle_pct = 0;

  // One color channel: Q10 sum with rounding, floor shift, then saturate to a byte.
  function automatic logic [7:0] saturate_q10(input int sum);
    int q = (sum + int'(ROUND_BIAS)) >>> 10;
    if (q < 0) begin
      return 8'd0;
    end
    if (q > 255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  function automatic logic [31:0] rgba_word(input logic [7:0] luma, input int u, input int v);
    int         rv = (shadow_matrix == MATRIX_BT709) ? int'(COEF_RV_709) : int'(COEF_RV_601);
    int         gu = (shadow_matrix == MATRIX_BT709) ? int'(COEF_GU_709) : int'(COEF_GU_601);
    int         gv = (shadow_matrix == MATRIX_BT709) ? int'(COEF_GV_709) : int'(COEF_GV_601);
    int         bu = (shadow_matrix == MATRIX_BT709) ? int'(COEF_BU_709) : int'(COEF_BU_601);
    int         yy = (int'(luma) - int'(LUMA_OFFSET)) * int'(COEF_Y);
    logic [7:0] red   = saturate_q10(yy + rv * v);
    logic [7:0] green = saturate_q10(yy + gu * u + gv * v);
    logic [7:0] blue  = saturate_q10(yy + bu * u);
    if (shadow_order == ORDER_RGBA) begin
      return {ALPHA_OPAQUE, blue, green, red};
    end
    return {ALPHA_OPAQUE, red, green, blue};
  endfunction

  // Both pixels of a pair share one chroma sample; its byte order follows the register.
  function automatic out_t rgba_pair_for(input in_t pair);
    int   c_first  = int'(pair.chroma_first) - 128;
    int   c_second = int'(pair.chroma_second) - 128;
    int   u        = (shadow_chroma == CHROMA_V_FIRST) ? c_second : c_first;
    int   v        = (shadow_chroma == CHROMA_V_FIRST) ? c_first : c_second;
    out_t pixels;
    pixels.pixel_left  = rgba_word(pair.luma_first, u, v);
    pixels.pixel_right = rgba_word(pair.luma_second, u, v);
    pixels.row_last    = pair.end_of_row;
    return pixels;
  endfunction

  // Everything is sampled at the rising edge, before the block's own updates land.
  // Results are checked first, then a new transaction is predicted, then a register
  // write is applied; the stimulus never writes a register while work is in flight.
  always @(posedge clk_i) begin
    out_t want;
    logic accepted;
    if (rst_ni) begin
      accepted = start_i && !busy_o;
      if (done_o) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result left=%h right=%h row_last=%b", $time,
                   result_o.pixel_left, result_o.pixel_right, result_o.row_last);
          error_count++;
        end else begin
          want = pending_pixels.pop_front();
          pairs_checked++;
          if (result_o.pixel_left !== want.pixel_left) begin
            $display("%0t: pixel_left expected %h actual %h", $time,
                     want.pixel_left, result_o.pixel_left);
            error_count++;
          end
          if (result_o.pixel_right !== want.pixel_right) begin
            $display("%0t: pixel_right expected %h actual %h", $time,
                     want.pixel_right, result_o.pixel_right);
            error_count++;
          end
          if (result_o.row_last !== want.row_last) begin
            $display("%0t: row_last expected %b actual %b", $time,
                     want.row_last, result_o.row_last);
            error_count++;
          end
        end
      end
      if (accepted) begin
        pending_pixels.push_back(rgba_pair_for(data_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COLOR_MATRIX: shadow_matrix = cfg_wdata_i[0];
          CFG_OUTPUT_ORDER: shadow_order  = cfg_wdata_i[0];
          CFG_CHROMA_ORDER: shadow_chroma = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accepted || done_o || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, pending_pixels.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Drives one pair and waits for the edge that accepts it. Start stays high into the
  // next transaction unless the sender decides to idle; then start drops for a random gap.
  task automatic send_pair(input in_t pair);
    int unsigned gap = 0;
    start_i <= 1'b1;
    data_i  <= pair;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    pairs_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 4);
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    start_i <= 1'b0;
  endtask

  // Waits until every pair sent so far has been checked; the block is idle when this
  // returns. Counting sent pairs keeps it independent of when the checker runs.
  task automatic drain_pixels();
    while (pairs_checked != pairs_sent) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic write_setting(input logic matrix, input logic order, input logic chroma);
    write_register(CFG_COLOR_MATRIX, matrix);
    write_register(CFG_OUTPUT_ORDER, order);
    write_register(CFG_CHROMA_ORDER, chroma);
  endtask

  function automatic in_t make_pair(input logic [7:0] y0, input logic [7:0] y1,
                                    input logic [7:0] c0, input logic [7:0] c1,
                                    input logic eor);
    in_t pair;
    pair.luma_first    = y0;
    pair.luma_second   = y1;
    pair.chroma_first  = c0;
    pair.chroma_second = c1;
    pair.end_of_row    = eor;
    return pair;
  endfunction

  // Samples lean toward the nominal limits and the byte ends a quarter of the time,
  // which is where the clamps and the offsets do their work.
  function automatic logic [7:0] pick_sample();
    logic [7:0] corners[5] = '{8'd0, 8'd16, 8'd128, 8'd235, 8'd255};
    if ($urandom_range(3) == 0) begin
      return corners[$urandom_range(4)];
    end
    return 8'($urandom_range(255));
  endfunction

  // Reset values: BT.601, BGRA packing, U first. Covers black and white at the nominal
  // limits, the byte extremes of every field and chroma that drives each channel
  // into both clamps.
  task automatic test_reset_setting();
    send_pair(make_pair(8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
    send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    send_pair(make_pair(8'd16,  8'd235, 8'd128, 8'd128, 1'b0));
    send_pair(make_pair(8'd0,   8'd255, 8'd0,   8'd255, 1'b1));
    send_pair(make_pair(8'd255, 8'd0,   8'd255, 8'd0,   1'b0));
    send_pair(make_pair(8'd235, 8'd16,  8'd240, 8'd16,  1'b1));
    stop_sending();
    drain_pixels();
  endtask

  // A write to the unmapped index must leave every setting alone; then all eight
  // combinations of the three registers are visited with asymmetric chroma so that
  // swapping U and V or the byte order shows up.
  task automatic test_register_settings();
    write_register(CFG_UNMAPPED, 1'b1);
    send_pair(make_pair(8'd128, 8'd200, 8'd60, 8'd200, 1'b0));
    stop_sending();
    drain_pixels();
    for (int combo = 7; combo >= 0; combo--) begin
      write_setting(combo[0], combo[1], combo[2]);
      send_pair(make_pair(8'd255, 8'd0,   8'd0,   8'd255, 1'b1));
      send_pair(make_pair(8'd16,  8'd235, 8'd255, 8'd0,   1'b0));
      stop_sending();
      drain_pixels();
    end
  endtask

  // Random traffic in phases of sender idling. The receiver cannot hold results off,
  // so only the sender side varies. Halfway through each phase the sender pauses until
  // every result is back, and each phase starts from a fresh random setting.
  task automatic test_random_traffic();
    int unsigned idle_plan[4] = '{0, 56, 0, 16};
    foreach (idle_plan[p]) begin
      write_setting(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      sender_idle_pct = idle_plan[p];
      for (int unsigned n = 0; n < RANDOM_PAIRS; n++) begin
        send_pair(make_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                            1'($urandom_range(1))));
        if (n == RANDOM_PAIRS / 2) begin
          stop_sending();
          drain_pixels();
        end
      end
      stop_sending();
      drain_pixels();
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_setting();
    test_register_settings();
    test_random_traffic();

    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixel pairs and checked %0d results; all eight register settings,",
             pairs_sent, pairs_checked);
    $display("the unmapped index, clamp extremes and four sender idling phases were run.");
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               pending_pixels.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/y2r_pkg.sv
rtl/core/y2r_chroma.sv
rtl/core/y2r_lane.sv
rtl/core/yuv420_pair_to_rgba_converter.sv
verif/tb_yuv420_pair_to_rgba_converter.sv
